FILE: hdl/rhrgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhrgb_pkg
// Shared types, register indexes, hue sector codes and the helper function of
// the range-to-hue colour unit.
// ----------------------------------------------------------------------------
package rhrgb_pkg;

    // Widths that the field definitions fix.
    localparam int RANGE_W = 12;
    localparam int CHAN_W  = 8;
    localparam int IDX_W   = 2;

    typedef logic [RANGE_W-1:0] t_range;
    typedef logic [CHAN_W-1:0]  t_chan;
    typedef logic [IDX_W-1:0]   t_cfg_idx;

    // Hue is held at most nine bits wide, enough for any span up to 359.
    typedef logic [8:0] t_hue_ext;
    typedef logic [5:0] t_sector_off;
    typedef logic [9:0] t_rem_scaled;
    typedef logic [15:0] t_prod;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_MIN_RANGE = 2'd0;
    localparam t_cfg_idx CFG_MAX_RANGE = 2'd1;
    localparam t_cfg_idx CFG_BRIGHT    = 2'd2;

    localparam t_range CFG_MIN_RESET    = 12'd30;
    localparam t_range CFG_MAX_RESET    = 12'd2500;
    localparam t_chan  CFG_BRIGHT_RESET = 8'd25;

    // Sixty-degree hue sectors.
    typedef logic [2:0] t_region;
    localparam t_region RGN_RED_YEL = 3'd0;
    localparam t_region RGN_YEL_GRN = 3'd1;
    localparam t_region RGN_GRN_CYN = 3'd2;
    localparam t_region RGN_CYN_BLU = 3'd3;
    localparam t_region RGN_BLU_MAG = 3'd4;
    localparam t_region RGN_MAG_RED = 3'd5;

    localparam int SECTOR_DEG  = 60;
    localparam int SECTOR_LAST = 5;

    // Exact floor(x / 255) for any 16-bit x below 65280, where the quotient fits in eight bits.
    function automatic t_chan div255(input t_prod x);
        logic [16:0] s;
        s = 17'(x) + 17'(x >> 8) + 17'd1;
        return s[15:8];
    endfunction

endpackage
`default_nettype wire

FILE: hdl/rhrgb_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhrgb_front
// Clamps the reading to the configured window and scales the offset by the
// hue span, giving the dividend and divisor for the divider chain.
// ----------------------------------------------------------------------------
module rhrgb_front #(
    parameter int HUE_SPAN = 240,
    parameter int NUM_W    = 21
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  rhrgb_pkg::t_range    i_range,
    input  rhrgb_pkg::t_range    i_min,
    input  rhrgb_pkg::t_range    i_max,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic [NUM_W-1:0]     o_num,
    output rhrgb_pkg::t_range    o_den
);

    logic              r_a_v, r_b_v;
    logic              a_rdy, b_rdy;
    rhrgb_pkg::t_range r_a_diff, r_a_den, r_b_den;
    logic [NUM_W-1:0]  r_b_num;
    rhrgb_pkg::t_range n_diff, n_den, w_lo, w_clamp;
    logic              w_empty;

    assign b_rdy   = !r_b_v || i_ready;
    assign a_rdy   = !r_a_v || b_rdy;
    assign o_ready = a_rdy;
    assign o_valid = r_b_v;
    assign o_num   = r_b_num;
    assign o_den   = r_b_den;

    // An empty or inverted window gives hue zero: a zero dividend over one.
    always_comb begin
        w_lo    = (i_range < i_min) ? i_min : i_range;
        w_clamp = (w_lo > i_max) ? i_max : w_lo;
        w_empty = (i_max <= i_min);
        n_diff  = w_empty ? '0 : w_clamp - i_min;
        n_den   = w_empty ? rhrgb_pkg::t_range'(1) : i_max - i_min;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (a_rdy) r_a_v <= i_valid;
            if (b_rdy) r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_rdy && i_valid) begin
            r_a_diff <= n_diff;
            r_a_den  <= n_den;
        end
        if (b_rdy && r_a_v) begin
            r_b_num <= NUM_W'(r_a_diff) * NUM_W'(HUE_SPAN);
            r_b_den <= r_a_den;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/rhrgb_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhrgb_div_cell
// One cell of the restoring divider chain: resolves a single quotient bit
// and hands the partial remainder on to the next cell.
// ----------------------------------------------------------------------------
module rhrgb_div_cell #(
    parameter int NUM_W = 21,
    parameter int QW    = 9,
    parameter int SHIFT = 0
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire  [NUM_W-1:0]     i_rem,
    input  rhrgb_pkg::t_range    i_den,
    input  wire  [QW-1:0]        i_quo,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic [NUM_W-1:0]     o_rem,
    output rhrgb_pkg::t_range    o_den,
    output logic [QW-1:0]        o_quo
);

    logic              r_v;
    logic [NUM_W-1:0]  r_rem, n_rem, w_trial;
    rhrgb_pkg::t_range r_den;
    logic [QW-1:0]     r_quo, n_quo;
    logic              w_fit;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quo   = r_quo;

    always_comb begin
        w_trial = NUM_W'(i_den) << SHIFT;
        w_fit   = (i_rem >= w_trial);
        n_rem   = w_fit ? i_rem - w_trial : i_rem;
        n_quo   = w_fit ? (i_quo | (QW'(1) << SHIFT)) : i_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_quo <= n_quo;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/rhrgb_hsv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhrgb_hsv
// Integer HSV to RGB conversion at full saturation, three stages: sector
// split, the two intensity products, then scaling and channel selection.
// ----------------------------------------------------------------------------
module rhrgb_hsv #(
    parameter int QW = 8
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire  [QW-1:0]        i_hue,
    input  rhrgb_pkg::t_chan     i_bright,
    output logic                 o_valid,
    input  wire                  i_ready,
    output rhrgb_pkg::t_chan     o_red,
    output rhrgb_pkg::t_chan     o_green,
    output rhrgb_pkg::t_chan     o_blue
);

    logic r1_v, r2_v, r3_v;
    logic rdy1, rdy2, rdy3;

    rhrgb_pkg::t_hue_ext    w_hue, w_base;
    rhrgb_pkg::t_region     n_region, r1_region, r2_region;
    rhrgb_pkg::t_sector_off w_off;
    rhrgb_pkg::t_rem_scaled w_scaled;
    rhrgb_pkg::t_chan       n_rem, r1_rem;
    rhrgb_pkg::t_prod       r2_q_prod, r2_t_prod;
    rhrgb_pkg::t_chan       w_q, w_t, w_v;
    rhrgb_pkg::t_chan       n_red, n_green, n_blue;
    rhrgb_pkg::t_chan       r3_red, r3_green, r3_blue;

    assign rdy3    = !r3_v || i_ready;
    assign rdy2    = !r2_v || rdy3;
    assign rdy1    = !r1_v || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r3_v;
    assign o_red   = r3_red;
    assign o_green = r3_green;
    assign o_blue  = r3_blue;

    // Sector number by comparison against the sector starts; the offset in
    // the sector is scaled from 0..59 to 0..250 by 17/4, which is 255/60.
    always_comb begin
        w_hue    = rhrgb_pkg::t_hue_ext'(i_hue);
        n_region = rhrgb_pkg::RGN_RED_YEL;
        w_base   = '0;
        for (int k = 1; k <= rhrgb_pkg::SECTOR_LAST; k++) begin
            if (w_hue >= rhrgb_pkg::t_hue_ext'(rhrgb_pkg::SECTOR_DEG * k)) begin
                n_region = rhrgb_pkg::t_region'(k);
                w_base   = rhrgb_pkg::t_hue_ext'(rhrgb_pkg::SECTOR_DEG * k);
            end
        end
        w_off    = rhrgb_pkg::t_sector_off'(w_hue - w_base);
        w_scaled = rhrgb_pkg::t_rem_scaled'(w_off) * 10'd17;
        n_rem    = rhrgb_pkg::t_chan'(w_scaled >> 2);
    end

    // The trailing value is zero throughout, since saturation is full.
    always_comb begin
        w_v = i_bright;
        w_q = rhrgb_pkg::div255(r2_q_prod);
        w_t = rhrgb_pkg::div255(r2_t_prod);
        unique case (r2_region)
            rhrgb_pkg::RGN_RED_YEL: begin
                n_red = w_v; n_green = w_t; n_blue = '0;
            end
            rhrgb_pkg::RGN_YEL_GRN: begin
                n_red = w_q; n_green = w_v; n_blue = '0;
            end
            rhrgb_pkg::RGN_GRN_CYN: begin
                n_red = '0; n_green = w_v; n_blue = w_t;
            end
            rhrgb_pkg::RGN_CYN_BLU: begin
                n_red = '0; n_green = w_q; n_blue = w_v;
            end
            rhrgb_pkg::RGN_BLU_MAG: begin
                n_red = w_t; n_green = '0; n_blue = w_v;
            end
            default: begin
                n_red = w_v; n_green = '0; n_blue = w_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= i_valid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r1_region <= n_region;
            r1_rem    <= n_rem;
        end
        if (rdy2 && r1_v) begin
            r2_region <= r1_region;
            r2_q_prod <= rhrgb_pkg::t_prod'(i_bright) *
                         rhrgb_pkg::t_prod'(8'hFF - r1_rem);
            r2_t_prod <= rhrgb_pkg::t_prod'(i_bright) * rhrgb_pkg::t_prod'(r1_rem);
        end
        if (rdy3 && r2_v) begin
            r3_red   <= n_red;
            r3_green <= n_green;
            r3_blue  <= n_blue;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/range_to_hue_rgb_color_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// range_to_hue_rgb_color_unit
// Maps a distance reading onto a hue between red and blue and gives the
// matching RGB colour.
// ----------------------------------------------------------------------------
// The unit takes one reading per clock when the output is not stalled and
// gives one colour beat per reading, in order. A reading passes through the
// clamping and scaling stages, one divider cell per quotient bit, and the
// HSV conversion stages. Each stage has its own valid bit and holds its beat
// under back-pressure, so bubbles close up and new readings are taken while a
// finished colour waits. Registers are read by the pipeline while beats are
// in flight; write them only when the unit is empty.
// ----------------------------------------------------------------------------
module range_to_hue_rgb_color_unit #(
    parameter int HUE_SPAN = 240
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // Input stream.
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire  [15:0]           i_s_axis_tdata,   // [11:0] range_cm
    // Output stream.
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    output logic [23:0]           o_m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    // Register writes.
    input  wire                   i_cfg_we,
    input  rhrgb_pkg::t_cfg_idx   i_cfg_idx,
    input  wire  [11:0]           i_cfg_wdata
);

    localparam int QW    = $clog2(HUE_SPAN + 1);
    localparam int NUM_W = rhrgb_pkg::RANGE_W + QW;

    rhrgb_pkg::t_range r_min, r_max;
    rhrgb_pkg::t_chan  r_bright;

    logic              front_v, front_rdy;
    logic [NUM_W-1:0]  front_num;
    rhrgb_pkg::t_range front_den;

    logic              c_v   [QW+1];
    logic              c_rdy [QW+1];
    logic [NUM_W-1:0]  c_rem [QW+1];
    rhrgb_pkg::t_range c_den [QW+1];
    logic [QW-1:0]     c_quo [QW+1];

    rhrgb_pkg::t_chan  red, green, blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= rhrgb_pkg::CFG_MIN_RESET;
            r_max    <= rhrgb_pkg::CFG_MAX_RESET;
            r_bright <= rhrgb_pkg::CFG_BRIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rhrgb_pkg::CFG_MIN_RANGE: r_min    <= i_cfg_wdata;
                rhrgb_pkg::CFG_MAX_RANGE: r_max    <= i_cfg_wdata;
                rhrgb_pkg::CFG_BRIGHT:    r_bright <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    rhrgb_front #(
        .HUE_SPAN (HUE_SPAN),
        .NUM_W    (NUM_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_range  (i_s_axis_tdata[11:0]),
        .i_min    (r_min),
        .i_max    (r_max),
        .o_valid  (front_v),
        .i_ready  (front_rdy),
        .o_num    (front_num),
        .o_den    (front_den)
    );

    assign c_v[0]    = front_v;
    assign front_rdy = c_rdy[0];
    assign c_rem[0]  = front_num;
    assign c_den[0]  = front_den;
    assign c_quo[0]  = '0;

    // Quotient bits resolve most significant first, one per cell.
    for (genvar k = 0; k < QW; k++) begin : g_cell
        rhrgb_div_cell #(
            .NUM_W (NUM_W),
            .QW    (QW),
            .SHIFT (QW - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_v[k]),
            .o_ready (c_rdy[k]),
            .i_rem   (c_rem[k]),
            .i_den   (c_den[k]),
            .i_quo   (c_quo[k]),
            .o_valid (c_v[k+1]),
            .i_ready (c_rdy[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_den   (c_den[k+1]),
            .o_quo   (c_quo[k+1])
        );
    end

    rhrgb_hsv #(
        .QW (QW)
    ) u_hsv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (c_v[QW]),
        .o_ready  (c_rdy[QW]),
        .i_hue    (c_quo[QW]),
        .i_bright (r_bright),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_red    (red),
        .o_green  (green),
        .o_blue   (blue)
    );

    assign o_m_axis_tdata = {blue, green, red};

endmodule
`default_nettype wire

FILE: hdl/rhrgb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhrgb_checker
// Port-level checks on the range-to-hue colour unit, bound to the top level.
// ----------------------------------------------------------------------------
module rhrgb_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_s_axis_tready,
    input wire                 o_m_axis_tvalid,
    input wire                 i_m_axis_tready,
    input wire [23:0]          o_m_axis_tdata
);

    // The pipeline comes out of reset empty.
    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output beat shown straight after reset");

    // An empty pipeline is always ready for a reading.
    a_ready_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> o_s_axis_tready)
        else $error("input not ready straight after reset");

    // A stalled colour beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled output beat changed");

    // At full saturation one channel is always dark.
    a_one_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[7:0] == 8'd0 ||
                             o_m_axis_tdata[15:8] == 8'd0 ||
                             o_m_axis_tdata[23:16] == 8'd0))
        else $error("no dark channel in output colour");

endmodule

bind range_to_hue_rgb_color_unit rhrgb_checker u_rhrgb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire
